// ----- src/tssm_pkg.sv -----
// tssm_pkg: operation codes, result status codes, stream widths and config
// port widths and register map for the shared-memory two-stack block and its port checker.
// depends on nothing
package tssm_pkg;

  // operation codes carried in s_axis_tuser[2:0]
  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_PEEK   = 3'd2;
  localparam logic [2:0] FN_CLEAR  = 3'd3;
  localparam logic [2:0] FN_SEARCH = 3'd4;

  // result status codes carried in m_axis_tuser
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  // config port widths and register map
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned REG_CAPACITY = 0;

endpackage

// ----- src/two_stacks_shared_memory.sv -----
// two_stacks_shared_memory: two lifo stacks in one synchronous memory,
// with push, pop, peek, clear and a linear search over both stacks.
// depends on tssm_pkg
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------
//  s_axis    | in  | tvalid / tready        | tdata value, tuser func/which_stack
//  m_axis    | out | tvalid / tready        | tdata result fields, tuser status
//  apb       | in  | psel / penable / pready| capacity register at address 0
//
// push, clear, refused items and unused codes give their result straight from idle;
// pop and peek wait in S_POP for the registered read data of the memory; a search
// reads one memory entry per cycle while scanning, over stack a, then stack b.
// reset clears both sizes and sets capacity to DEPTH; memory words are not
// cleared. the result register holds while m_axis_tready is low, and a new
// item is taken in the same cycle the waiting result is taken.
module two_stacks_shared_memory #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tssm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [31:0] value
  input  logic [tssm_pkg::IN_USER_W-1:0]      s_axis_tuser,  // [2:0] func, [3] which_stack
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] data_out, [32] found_stack, [42:33] found_index, [53:43] size_a,
  // [64:54] size_b, [65] is_full, [71:66] zero
  output logic [tssm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [tssm_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // [1:0] status
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tssm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tssm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tssm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH
  } state_e;

  state_e                     st_q, st_d;
  logic [CW-1:0]              top_a_q, top_a_d;
  logic [CW-1:0]              count_b_q, count_b_d;
  logic [tssm_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [CW-1:0]              eff_cap_q, eff_cap_d;
  logic [DATA_WIDTH-1:0]      val_q, val_d;
  logic [CW-1:0]              scan_addr_q, scan_addr_d;
  logic                       scan_b_q, scan_b_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]              cmp_addr_q, cmp_addr_d;
  logic                       cmp_b_q, cmp_b_d;

  // result register
  logic                       m_vld_q, m_vld_d;
  logic [1:0]                 status_q, status_d;
  logic [31:0]                data_q, data_d;
  logic                       fstack_q, fstack_d;
  logic [9:0]                 findex_q, findex_d;
  logic [10:0]                size_a_q, size_a_d;
  logic [10:0]                size_b_q, size_b_d;
  logic                       full_q, full_d;

  // memory port
  logic [DATA_WIDTH-1:0]      mem_q [DEPTH];
  logic [DATA_WIDTH-1:0]      rd_data_q;
  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0]      wr_data;

  // input decode
  logic                       in_acc;
  logic [2:0]                 in_func;
  logic                       in_b;
  logic [DATA_WIDTH-1:0]      in_val;
  logic                       cfg_we;
  logic [CW-1:0]              b_base;
  logic                       full_now;
  logic                       ld_out;
  logic                       match;
  logic [CW:0]                sum_d;

  assign in_func = s_axis_tuser[2:0];
  assign in_b    = s_axis_tuser[3];
  assign in_val  = DATA_WIDTH'(s_axis_tdata);

  assign s_axis_tready = (st_q == S_IDLE) && (!m_vld_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // apb: always ready, one register at word 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[2] == 1'(tssm_pkg::REG_CAPACITY));
  assign prdata = (paddr[2] == 1'(tssm_pkg::REG_CAPACITY))
                  ? {{(tssm_pkg::CFG_DATA_W - tssm_pkg::CAP_W){1'b0}}, cap_q}
                  : '0;

  // lowest index held by stack b, and the push-refusal check
  assign b_base   = eff_cap_q - count_b_q;
  assign full_now = ({1'b0, top_a_q} + {1'b0, count_b_q}) >= {1'b0, eff_cap_q};
  assign match    = cmp_vld_q && (rd_data_q == val_q);

  // next-state and result logic
  always_comb begin
    st_d        = st_q;
    top_a_d     = top_a_q;
    count_b_d   = count_b_q;
    cap_d       = cap_q;
    eff_cap_d   = eff_cap_q;
    val_d       = val_q;
    scan_addr_d = scan_addr_q;
    scan_b_d    = scan_b_q;
    cmp_vld_d   = 1'b0;
    cmp_addr_d  = cmp_addr_q;
    cmp_b_d     = cmp_b_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = in_val;
    ld_out      = 1'b0;
    status_d    = tssm_pkg::ST_OK;
    data_d      = '0;
    fstack_d    = 1'b0;
    findex_d    = '0;

    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_func)
            tssm_pkg::FN_PUSH: begin
              ld_out = 1'b1;
              if (full_now) begin
                status_d = tssm_pkg::ST_FULL;
              end else if (!in_b) begin
                wr_en   = 1'b1;
                wr_addr = top_a_q[AW-1:0];
                top_a_d = top_a_q + CW'(1);
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(b_base - CW'(1));
                count_b_d = count_b_q + CW'(1);
              end
            end
            tssm_pkg::FN_POP, tssm_pkg::FN_PEEK: begin
              if (!in_b) begin
                if (top_a_q == '0) begin
                  ld_out   = 1'b1;
                  status_d = tssm_pkg::ST_EMPTY;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(top_a_q - CW'(1));
                  st_d    = S_POP;
                  if (in_func == tssm_pkg::FN_POP) begin
                    top_a_d = top_a_q - CW'(1);
                  end
                end
              end else begin
                if (count_b_q == '0) begin
                  ld_out   = 1'b1;
                  status_d = tssm_pkg::ST_EMPTY;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = b_base[AW-1:0];
                  st_d    = S_POP;
                  if (in_func == tssm_pkg::FN_POP) begin
                    count_b_d = count_b_q - CW'(1);
                  end
                end
              end
            end
            tssm_pkg::FN_CLEAR: begin
              ld_out    = 1'b1;
              top_a_d   = '0;
              count_b_d = '0;
            end
            tssm_pkg::FN_SEARCH: begin
              val_d       = in_val;
              scan_addr_d = '0;
              scan_b_d    = 1'b0;
              st_d        = S_SRCH;
            end
            default: begin
              ld_out = 1'b1;
            end
          endcase
        end
      end

      // popped or peeked word arrives from the memory read register
      S_POP: begin
        if (!m_vld_q || m_axis_tready) begin
          ld_out = 1'b1;
          data_d = 32'(rd_data_q);
          st_d   = S_IDLE;
        end
      end

      // one read issued per cycle while no match is waiting, compared in the cycle after
      S_SRCH: begin
        if (match) begin
          if (!m_vld_q || m_axis_tready) begin
            ld_out   = 1'b1;
            fstack_d = cmp_b_q;
            findex_d = 10'(cmp_addr_q);
            st_d     = S_IDLE;
          end else begin
            cmp_vld_d = 1'b1;
          end
        end else if (!scan_b_q) begin
          if (scan_addr_q == top_a_q) begin
            scan_addr_d = b_base;
            scan_b_d    = 1'b1;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = scan_addr_q[AW-1:0];
            cmp_vld_d   = 1'b1;
            cmp_addr_d  = scan_addr_q[AW-1:0];
            cmp_b_d     = 1'b0;
            scan_addr_d = scan_addr_q + CW'(1);
          end
        end else if (scan_addr_q != eff_cap_q) begin
          rd_en       = 1'b1;
          rd_addr     = scan_addr_q[AW-1:0];
          cmp_vld_d   = 1'b1;
          cmp_addr_d  = scan_addr_q[AW-1:0];
          cmp_b_d     = 1'b1;
          scan_addr_d = scan_addr_q + CW'(1);
        end else if (!cmp_vld_q && (!m_vld_q || m_axis_tready)) begin
          ld_out   = 1'b1;
          status_d = tssm_pkg::ST_NOTFOUND;
          st_d     = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase

    // capacity write empties both stacks
    if (cfg_we) begin
      cap_d     = pwdata[tssm_pkg::CAP_W-1:0];
      top_a_d   = '0;
      count_b_d = '0;
      if (32'(pwdata[tssm_pkg::CAP_W-1:0]) > 32'(DEPTH)) begin
        eff_cap_d = CW'(DEPTH);
      end else begin
        eff_cap_d = CW'(pwdata[tssm_pkg::CAP_W-1:0]);
      end
    end

    // sizes and full flag after the item
    sum_d    = {1'b0, top_a_d} + {1'b0, count_b_d};
    size_a_d = 11'(top_a_d);
    size_b_d = 11'(count_b_d);
    full_d   = sum_d >= {1'b0, eff_cap_q};

    if (ld_out) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end else begin
      m_vld_d = m_vld_q;
    end
  end

  // state, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      top_a_q     <= '0;
      count_b_q   <= '0;
      cap_q       <= tssm_pkg::CAP_W'(DEPTH);
      eff_cap_q   <= CW'(DEPTH);
      val_q       <= '0;
      scan_addr_q <= '0;
      scan_b_q    <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_addr_q  <= '0;
      cmp_b_q     <= 1'b0;
      m_vld_q     <= 1'b0;
      status_q    <= '0;
      data_q      <= '0;
      fstack_q    <= 1'b0;
      findex_q    <= '0;
      size_a_q    <= '0;
      size_b_q    <= '0;
      full_q      <= 1'b0;
    end else begin
      st_q        <= st_d;
      top_a_q     <= top_a_d;
      count_b_q   <= count_b_d;
      cap_q       <= cap_d;
      eff_cap_q   <= eff_cap_d;
      val_q       <= val_d;
      scan_addr_q <= scan_addr_d;
      scan_b_q    <= scan_b_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_addr_q  <= cmp_addr_d;
      cmp_b_q     <= cmp_b_d;
      m_vld_q     <= m_vld_d;
      if (ld_out) begin
        status_q <= status_d;
        data_q   <= data_d;
        fstack_q <= fstack_d;
        findex_q <= findex_d;
        size_a_q <= size_a_d;
        size_b_q <= size_b_d;
        full_q   <= full_d;
      end
    end
  end

  // stack memory, one access per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // result stream
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {6'b0, full_q, size_b_q, size_a_q, findex_q, fstack_q, data_q};

endmodule

// ----- src/tssm_check.sv -----
// tssm_check: port-level checks on the result stream of the two-stack block,
// attached to two_stacks_shared_memory by the bind at the end of this file.
// depends on tssm_pkg
module tssm_check #(
  parameter int unsigned DEPTH = 1024
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tssm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [tssm_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  logic [11:0] size_sum;

  assign size_sum = {1'b0, m_axis_tdata[53:43]} + {1'b0, m_axis_tdata[64:54]};

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // data and match location only come with an ok status
  a_zero_on_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != tssm_pkg::ST_OK) |->
      (m_axis_tdata[42:0] == '0))
    else $error("payload not zero on refused item");

  // a refused push always shows the full flag
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tssm_pkg::ST_FULL) |-> m_axis_tdata[65])
    else $error("full status without full flag");

  // both stacks together never exceed the memory, and the unused top bits are zero
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(size_sum) <= 32'(DEPTH)) && (m_axis_tdata[71:66] == '0))
    else $error("stack sizes exceed memory depth");

endmodule

bind two_stacks_shared_memory tssm_check #(.DEPTH(DEPTH)) u_tssm_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
